### hw/rtl/crc16fr_pkg.sv
// Package for the CRC16 frame receiver: widths, sync and CRC constants,
// the byte-wise CRC16-CCITT-FALSE update and the controller/datapath structs.
// Depends on nothing.
`default_nettype none

package crc16fr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int STORE_LIMIT     = 32;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 6;
  localparam int IDX_W           = 5;
  localparam int CRC_W           = 16;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_cmd;
    logic load_len;
    logic store_byte;
    logic load_crc_hi;
    logic start_emit;
    logic advance;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sync_first;
    logic is_sync_second;
    logic len_ok;
    logic len_zero;
    logic payload_done;
    logic emit_last;
  } dp_status_t;

  // One byte through the CRC register, most significant bit first.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] acc,
                                                input logic [BYTE_W-1:0] v);
    logic [CRC_W-1:0] r;
    r = acc ^ {v, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/crc16fr_dp.sv
// Datapath of the CRC16 frame receiver: header registers, running CRC,
// payload store and the result field logic. Depends on crc16fr_pkg.
`default_nettype none

module crc16fr_dp #(
  parameter int STORE_DEPTH = crc16fr_pkg::STORE_LIMIT
) (
  input  wire logic                            clk,
  input  wire logic [crc16fr_pkg::BYTE_W-1:0]  rx_byte,
  input  wire crc16fr_pkg::ctrl_cmd_t          cmd,
  output crc16fr_pkg::dp_status_t              status,
  output logic                                 frame_status,
  output logic [crc16fr_pkg::BYTE_W-1:0]       command,
  output logic [crc16fr_pkg::LEN_W-1:0]        payload_length,
  output logic                                 payload_valid,
  output logic [crc16fr_pkg::BYTE_W-1:0]       payload_byte,
  output logic [crc16fr_pkg::IDX_W-1:0]        byte_index,
  output logic                                 last
);
  import crc16fr_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [BYTE_W-1:0] command_reg;
  logic [LEN_W-1:0]  length_reg;
  logic [LEN_W-1:0]  index_reg;
  logic [CRC_W-1:0]  running_crc;
  logic [BYTE_W-1:0] crc_high_byte;
  logic              bad_crc;
  logic [AW-1:0]     emit_idx;
  logic [BYTE_W-1:0] read_data;
  logic [BYTE_W-1:0] payload_store [STORE_DEPTH];

  logic [LEN_W-1:0]  index_inc;
  logic [LEN_W-1:0]  emit_inc;
  logic [AW-1:0]     emit_next;
  logic              crc_match;

  assign index_inc = index_reg + LEN_W'(1);
  assign emit_inc  = LEN_W'(emit_idx) + LEN_W'(1);
  assign emit_next = emit_idx + AW'(1);
  assign crc_match = ({crc_high_byte, rx_byte} == running_crc);

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      command_reg <= rx_byte;
      running_crc <= crc_feed(CRC_INIT, rx_byte);
    end
    if (cmd.load_len) begin
      length_reg  <= rx_byte[LEN_W-1:0];
      index_reg   <= '0;
      running_crc <= crc_feed(running_crc, rx_byte);
    end
    if (cmd.store_byte) begin
      payload_store[index_reg[AW-1:0]] <= rx_byte;
      index_reg   <= index_inc;
      running_crc <= crc_feed(running_crc, rx_byte);
    end
    if (cmd.load_crc_hi) begin
      crc_high_byte <= rx_byte;
    end
    // The store is read one item ahead, so the byte for the next item is
    // already registered when that item goes out.
    if (cmd.start_emit) begin
      bad_crc   <= ~crc_match;
      emit_idx  <= '0;
      read_data <= payload_store[0];
    end else if (cmd.advance) begin
      emit_idx <= emit_next;
      if (!last) begin
        read_data <= payload_store[emit_next];
      end
    end
  end

  assign status.is_sync_first  = (rx_byte == SYNC_FIRST);
  assign status.is_sync_second = (rx_byte == SYNC_SECOND);
  assign status.len_ok         = (rx_byte <= BYTE_W'(STORE_DEPTH));
  assign status.len_zero       = (rx_byte == '0);
  assign status.payload_done   = (index_inc >= length_reg);
  assign status.emit_last      = last;

  // A bad frame and an empty good frame each give one header-only item.
  always_comb begin
    frame_status   = bad_crc;
    command        = command_reg;
    payload_length = length_reg;
    payload_valid  = ~bad_crc && (length_reg != '0);
    payload_byte   = payload_valid ? read_data : '0;
    byte_index     = payload_valid ? IDX_W'(emit_idx) : '0;
    last           = ~payload_valid || (emit_inc == length_reg);
  end

endmodule

`default_nettype wire

### hw/rtl/crc16fr_ctrl.sv
// Controller of the CRC16 frame receiver: the frame parsing state machine
// and the input/output handshake. Depends on crc16fr_pkg.
`default_nettype none

module crc16fr_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire crc16fr_pkg::dp_status_t status,
  output crc16fr_pkg::ctrl_cmd_t       cmd
);
  import crc16fr_pkg::*;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_CMD,
    GET_LEN,
    GET_PAYLOAD,
    GET_CRC_HI,
    GET_CRC_LO,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   out_fire;

  assign in_stall  = (state == EMIT);
  assign out_valid = (state == EMIT);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      HUNT_FIRST: begin
        if (in_fire && status.is_sync_first) state_next = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (in_fire) begin
          if (status.is_sync_second) begin
            state_next = GET_CMD;
          end else if (!status.is_sync_first) begin
            state_next = HUNT_FIRST;
          end
        end
      end
      GET_CMD: begin
        if (in_fire) begin
          cmd.load_cmd = 1'b1;
          state_next   = GET_LEN;
        end
      end
      GET_LEN: begin
        if (in_fire) begin
          if (status.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = status.len_zero ? GET_CRC_HI : GET_PAYLOAD;
          end else begin
            state_next = HUNT_FIRST;
          end
        end
      end
      GET_PAYLOAD: begin
        if (in_fire) begin
          cmd.store_byte = 1'b1;
          if (status.payload_done) state_next = GET_CRC_HI;
        end
      end
      GET_CRC_HI: begin
        if (in_fire) begin
          cmd.load_crc_hi = 1'b1;
          state_next      = GET_CRC_LO;
        end
      end
      GET_CRC_LO: begin
        if (in_fire) begin
          cmd.start_emit = 1'b1;
          state_next     = EMIT;
        end
      end
      EMIT: begin
        if (out_fire) begin
          cmd.advance = 1'b1;
          if (status.emit_last) state_next = HUNT_FIRST;
        end
      end
      default: state_next = HUNT_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HUNT_FIRST;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/crc16_frame_receiver.sv
// CRC16 frame receiver. Each input item is one received byte; the block finds
// the sync pair 0xAA 0x55, then takes a command byte, a length byte, that many
// payload bytes and a big-endian CRC16-CCITT-FALSE over command, length and
// payload. Frame bytes are taken one per cycle. After the last CRC byte the
// input is stalled while the results go out, one per cycle when not stalled:
// one item per payload byte for a good frame, or a single header item for an
// empty frame or a CRC mismatch. So no byte of the next frame is taken until
// the last result of the frame before it has gone out. Lengths above the
// store depth drop the frame without a result. Depends on crc16fr_pkg.
`default_nettype none

module crc16_frame_receiver #(
  parameter int MAX_PAYLOAD = crc16fr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [crc16fr_pkg::BYTE_W-1:0] rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                frame_status,
  output logic [crc16fr_pkg::BYTE_W-1:0]      command,
  output logic [crc16fr_pkg::LEN_W-1:0]       payload_length,
  output logic                                payload_valid,
  output logic [crc16fr_pkg::BYTE_W-1:0]      payload_byte,
  output logic [crc16fr_pkg::IDX_W-1:0]       byte_index,
  output logic                                last
);
  import crc16fr_pkg::*;

  localparam int STORE_DEPTH = (MAX_PAYLOAD < STORE_LIMIT) ? MAX_PAYLOAD : STORE_LIMIT;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  crc16fr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  crc16fr_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .status         (status),
    .frame_status   (frame_status),
    .command        (command),
    .payload_length (payload_length),
    .payload_valid  (payload_valid),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .last           (last)
  );

endmodule

`default_nettype wire
